[hdl/srrip_pkg.sv]
// Shared types and constants of the SRRIP replacement unit with bypass marking.
// Used by srrip_ctrl, srrip_dp, srrip_checker and the top level.
`default_nettype none

package srrip_pkg;

    // Default geometry
    localparam int SRRIP_SETS = 2048;
    localparam int SRRIP_WAYS = 16;

    // Field widths
    localparam int SET_IDX_W = 11;
    localparam int WAY_W     = 4;
    localparam int KIND_W    = 3;
    localparam int RRPV_W    = 3;

    // Stream payload widths
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 1;

    // Re-reference values
    localparam logic [RRPV_W-1:0] RRPV_HIT    = 3'd0;
    localparam logic [RRPV_W-1:0] RRPV_FILL   = 3'd2;
    localparam logic [RRPV_W-1:0] RRPV_MAX    = 3'd3;
    localparam logic [RRPV_W-1:0] RRPV_BYPASS = 3'd4;

    // Request commands
    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // Access kinds
    localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RFO       = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PREFETCH  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITEBACK = 3'd3;

    // Controller to datapath
    typedef struct packed {
        logic in_load;   // capture accepted request
        logic quot_en;   // register set quotient
        logic rd_issue;  // read set row
        logic row_wr;    // write modified row, load result
        logic clr_wr;    // write reset row during clearing pass
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;  // clearing pass at last row
        logic out_free;  // result register can take a new result
    } t_stat;

endpackage

`default_nettype wire

[hdl/srrip_ctrl.sv]
// Sequencer of the SRRIP unit: clearing pass, then per request quotient,
// row read and row write. Uses srrip_pkg; drives srrip_dp by t_cmd.
`default_nettype none

module srrip_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire srrip_pkg::t_stat i_stat,
    output srrip_pkg::t_cmd      o_cmd
);
    import srrip_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_READ,
        ST_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_QUOT;
            ST_QUOT:  n_state = ST_READ;
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: if (i_stat.out_free) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_cmd.in_load   = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.quot_en   = (r_state == ST_QUOT);
    assign o_cmd.rd_issue  = (r_state == ST_READ);
    // hold the row until the result register frees up
    assign o_cmd.row_wr    = (r_state == ST_WRITE) && i_stat.out_free;
    assign o_cmd.clr_wr    = (r_state == ST_CLEAR);

endmodule

`default_nettype wire

[hdl/srrip_dp.sv]
// Datapath of the SRRIP unit: request registers, set index reduction,
// row memory, victim search and aging, result register. Uses srrip_pkg.
`default_nettype none

module srrip_dp #(
    parameter int SETS = srrip_pkg::SRRIP_SETS,
    parameter int WAYS = srrip_pkg::SRRIP_WAYS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire srrip_pkg::t_cmd                   i_cmd,
    output srrip_pkg::t_stat                       o_stat,
    input  wire logic                              i_command,
    input  wire logic [srrip_pkg::SET_IDX_W-1:0]   i_set_index,
    input  wire logic [srrip_pkg::WAY_W-1:0]       i_way,
    input  wire logic                              i_hit,
    input  wire logic [srrip_pkg::KIND_W-1:0]      i_access_kind,
    input  wire logic                              i_set_full,
    input  wire logic                              i_filter_hit,
    input  wire logic                              i_cfg_valid,
    input  wire logic                              i_cfg_data,
    output logic                                   o_cfg_ready,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic [srrip_pkg::WAY_W-1:0]            o_victim_way,
    output logic                                   o_bypassed
);
    import srrip_pkg::*;

    localparam int SET_AW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int ROW_W  = WAYS * RRPV_W;
    localparam int MOD_K  = 28;
    localparam int PROD_W = SET_IDX_W + MOD_K + 1;
    // floor(x / SETS) == (x * MOD_M) >> MOD_K for every 11-bit x
    localparam logic [MOD_K:0] MOD_M =
        (MOD_K + 1)'(((64'd1 << MOD_K) + 64'(SETS) - 64'd1) / 64'(SETS));
    localparam logic [ROW_W-1:0] CLEAR_ROW = {WAYS{RRPV_MAX}};

    // Request registers
    logic                 r_command;
    logic [SET_IDX_W-1:0] r_x;
    logic [WAY_W-1:0]     r_way;
    logic                 r_hit;
    logic [KIND_W-1:0]    r_kind;
    logic                 r_full;
    logic                 r_fhit;
    logic [SET_IDX_W-1:0] r_q;
    logic [SET_AW-1:0]    r_addr;

    // Control registers
    logic                 r_byp_en;
    logic [SET_AW-1:0]    r_clr;
    logic                 r_out_valid;
    logic [WAY_W-1:0]     r_victim;
    logic                 r_bypassed;

    // Row memory
    logic [ROW_W-1:0]     r_mem [SETS];
    logic [ROW_W-1:0]     r_rd_row;

    logic [PROD_W-1:0]    w_prod;
    logic [SET_IDX_W-1:0] w_qd;
    logic [SET_IDX_W-1:0] w_rem;
    logic [SET_AW-1:0]    w_rd_addr;
    logic [SET_AW-1:0]    w_mem_rd_addr;
    logic [SET_AW-1:0]    w_mem_wr_addr;
    logic [ROW_W-1:0]     w_mem_wr_data;
    logic                 w_mem_wr_en;

    logic [RRPV_W-1:0]    w_vals [WAYS];
    logic                 w_byp_found;
    logic [WAY_W-1:0]     w_byp_way;
    logic                 w_any3;
    logic                 w_any2;
    logic                 w_any1;
    logic [RRPV_W-1:0]    w_top;
    logic [RRPV_W-1:0]    w_add;
    logic [WAY_W-1:0]     w_top_way;
    logic                 w_upd_valid;
    logic                 w_byp_mark;
    logic [RRPV_W-1:0]    w_upd_val;
    logic [ROW_W-1:0]     w_new_row;
    logic [WAY_W-1:0]     w_victim;
    logic                 w_bypassed;

    // Set index reduction: registered quotient, then remainder from it
    assign w_prod        = PROD_W'(r_x) * PROD_W'(MOD_M);
    assign w_qd          = SET_IDX_W'(32'(r_q) * SETS);
    assign w_rem         = r_x - w_qd;
    assign w_rd_addr     = SET_AW'(w_rem);
    assign w_mem_rd_addr = i_cmd.rd_issue ? w_rd_addr : r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_command <= i_command;
            r_x       <= i_set_index;
            r_way     <= i_way;
            r_hit     <= i_hit;
            r_kind    <= i_access_kind;
            r_full    <= i_set_full;
            r_fhit    <= i_filter_hit;
        end
        if (i_cmd.quot_en) begin
            r_q <= w_prod[SET_IDX_W+MOD_K-1:MOD_K];
        end
        if (i_cmd.rd_issue) begin
            r_addr <= w_rd_addr;
        end
    end

    // Row memory: one write, one registered read
    assign w_mem_wr_en   = i_cmd.clr_wr || i_cmd.row_wr;
    assign w_mem_wr_addr = i_cmd.clr_wr ? r_clr : r_addr;
    assign w_mem_wr_data = i_cmd.clr_wr ? CLEAR_ROW : w_new_row;

    always_ff @(posedge i_clk) begin
        if (w_mem_wr_en) begin
            r_mem[w_mem_wr_addr] <= w_mem_wr_data;
        end
        r_rd_row <= r_mem[w_mem_rd_addr];
    end

    // Victim search and aging on the row read
    always_comb begin
        for (int i = 0; i < WAYS; i++) begin
            w_vals[i] = r_rd_row[i*RRPV_W +: RRPV_W];
        end

        w_byp_found = 1'b0;
        w_byp_way   = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_vals[i] == RRPV_BYPASS) begin
                w_byp_found = 1'b1;
                w_byp_way   = WAY_W'(i);
            end
        end

        // without a bypass mark every value is at most 3
        w_any3 = 1'b0;
        w_any2 = 1'b0;
        w_any1 = 1'b0;
        for (int i = 0; i < WAYS; i++) begin
            w_any3 = w_any3 | (w_vals[i] == RRPV_MAX);
            w_any2 = w_any2 | (w_vals[i] == 3'd2);
            w_any1 = w_any1 | (w_vals[i] == 3'd1);
        end
        priority if (w_any3) w_top = 3'd3;
        else if (w_any2)     w_top = 3'd2;
        else if (w_any1)     w_top = 3'd1;
        else                 w_top = 3'd0;
        w_add = RRPV_MAX - w_top;

        // first way at the largest value becomes 3 after aging
        w_top_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_vals[i] == w_top) begin
                w_top_way = WAY_W'(i);
            end
        end

        w_upd_valid = (r_kind != KIND_WRITEBACK) && (int'(r_way) < WAYS);
        w_byp_mark  = r_byp_en && !r_hit && (r_kind <= KIND_PREFETCH)
                      && r_full && !r_fhit;
        priority if (w_byp_mark) w_upd_val = RRPV_BYPASS;
        else if (r_hit)          w_upd_val = RRPV_HIT;
        else                     w_upd_val = RRPV_FILL;

        for (int i = 0; i < WAYS; i++) begin
            if (r_command == CMD_FIND) begin
                w_new_row[i*RRPV_W +: RRPV_W] = w_byp_found ? w_vals[i]
                                                            : w_vals[i] + w_add;
            end else begin
                w_new_row[i*RRPV_W +: RRPV_W] =
                    (w_upd_valid && int'(r_way) == i) ? w_upd_val : w_vals[i];
            end
        end

        if (r_command == CMD_FIND) begin
            w_victim   = w_byp_found ? w_byp_way : w_top_way;
            w_bypassed = 1'b0;
        end else begin
            w_victim   = '0;
            w_bypassed = w_upd_valid && w_byp_mark;
        end
    end

    // Control registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_en    <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_byp_en <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.row_wr) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_wr) begin
            r_victim   <= w_victim;
            r_bypassed <= w_bypassed;
        end
    end

    assign o_stat.clr_last = (r_clr == SET_AW'(SETS - 1));
    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_victim_way    = r_victim;
    assign o_bypassed      = r_bypassed;

endmodule

`default_nettype wire

[hdl/srrip_replacement_with_bypass_unit.sv]
// SRRIP replacement unit with filter-driven bypass marking, top level.
// Joins srrip_ctrl and srrip_dp; uses srrip_pkg.
`default_nettype none

// One request is taken at a time and goes through these steps in order: capture
// at acceptance, set index quotient, set row read, then modify and write back of
// the row, which is also when the result is loaded. The result is then held in
// the output register, and the next request is accepted only after the write.
// The row memory's single read and write port and the reciprocal multiply that
// folds the set index into SETS shape these steps. The write step waits while a
// previous result is still held by the downstream side. After reset the unit
// runs a clearing pass over all SETS rows that sets every way value to 3; no
// request is accepted during it, configuration writes are. bypass_enable is
// written through the cfg channel, which is always ready.

module srrip_replacement_with_bypass_unit #(
    parameter int SETS = srrip_pkg::SRRIP_SETS,
    parameter int WAYS = srrip_pkg::SRRIP_WAYS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // set_index[10:0], way[14:11], hit[15], set_full[16], filter_hit[17], zero
    input  wire logic [srrip_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // command[0], access_kind[3:1]
    input  wire logic [srrip_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // victim_way[3:0], zero
    output logic [srrip_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // bypassed[0]
    output logic [srrip_pkg::OUT_TUSER_W-1:0]        m_axis_tuser,
    input  wire logic                                i_cfg_valid,
    input  wire logic                                i_cfg_data,
    output logic                                     o_cfg_ready
);
    import srrip_pkg::*;

    t_cmd             w_cmd;
    t_stat            w_stat;
    logic [WAY_W-1:0] w_victim;
    logic             w_bypassed;

    srrip_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    srrip_dp #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (s_axis_tuser[0]),
        .i_set_index   (s_axis_tdata[10:0]),
        .i_way         (s_axis_tdata[14:11]),
        .i_hit         (s_axis_tdata[15]),
        .i_access_kind (s_axis_tuser[3:1]),
        .i_set_full    (s_axis_tdata[16]),
        .i_filter_hit  (s_axis_tdata[17]),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_victim_way  (w_victim),
        .o_bypassed    (w_bypassed)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - WAY_W)'(0), w_victim};
    assign m_axis_tuser = w_bypassed;

endmodule

`default_nettype wire

[hdl/srrip_checker.sv]
// Port-level assertions for the SRRIP replacement unit, bound to the top level.
// Uses srrip_pkg for port widths.
`default_nettype none

module srrip_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [srrip_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic [srrip_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    input  wire logic                                i_cfg_valid,
    input  wire logic                                o_cfg_ready
);
    import srrip_pkg::*;

    // Stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One request in flight: no acceptance right after one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // A result follows each acceptance on the output
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##4 m_axis_tvalid)
        else $error("no result after accepted request");

    // Bypass marking comes only from updates, which return way zero
    a_bypass_way_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("bypassed result with nonzero victim way");

    // Configuration writes are never held off
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration transaction stalled");

endmodule

bind srrip_replacement_with_bypass_unit srrip_checker u_checker (.*);

`default_nettype wire
